@@ rtl/sswrm_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and microcode program of the skid-steer wheel rate mapper
package sswrm_pkg;

  // number format and polynomial size
  localparam int MAX_TERMS = 8;
  localparam int FRAC_BITS = 16;
  localparam int KW        = $clog2(MAX_TERMS);

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIM_BYPASS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RADIUS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_TRACK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LINEAR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINEAR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGULAR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGULAR = 3'd6;

  // item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // input item
  typedef struct packed {
    logic              op;
    logic              channel;
    logic [2:0]        coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] linear_cmd;
    logic signed [31:0] angular_cmd;
    logic signed [31:0] terrain_factor;
    logic signed [31:0] left_scale;
    logic signed [31:0] right_scale;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [31:0] left_wheel_rate;
    logic signed [31:0] right_wheel_rate;
    logic               saturated;
  } out_item_t;

  // multiplier operand select
  typedef enum logic [3:0] {
    SRC_ACCL, SRC_ACCA, SRC_XL, SRC_XA, SRC_INVR, SRC_HTR,
    SRC_TERR, SRC_T1, SRC_LS, SRC_RS, SRC_DIF, SRC_SUM
  } src_e;

  // post-multiply operation on the held product
  typedef enum logic [2:0] {
    POST_NOP, POST_MOV, POST_COEF, POST_BMINUS, POST_BPLUS
  } post_e;

  // destination of the post-multiply result
  typedef enum logic [2:0] {
    DST_ACCL, DST_ACCA, DST_BASE, DST_T1, DST_DIF, DST_SUM, DST_LEFT, DST_RIGHT
  } dst_e;

  // jump conditions
  typedef enum logic [1:0] {
    JMP_NONE, JMP_ALWAYS, JMP_BYPASS, JMP_KZERO
  } jmp_e;

  // program counter and step addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] PC_H0    = 4'd0;
  localparam logic [PC_W-1:0] PC_H1    = 4'd1;
  localparam logic [PC_W-1:0] PC_H2    = 4'd2;
  localparam logic [PC_W-1:0] PC_HE    = 4'd3;
  localparam logic [PC_W-1:0] PC_BP    = 4'd4;
  localparam logic [PC_W-1:0] PC_BASE  = 4'd5;
  localparam logic [PC_W-1:0] PC_T1    = 4'd6;
  localparam logic [PC_W-1:0] PC_TURN  = 4'd7;
  localparam logic [PC_W-1:0] PC_DIF   = 4'd8;
  localparam logic [PC_W-1:0] PC_SUM   = 4'd9;
  localparam logic [PC_W-1:0] PC_LEFT  = 4'd10;
  localparam logic [PC_W-1:0] PC_RIGHT = 4'd11;

  // one control word
  typedef struct packed {
    logic            mul_en;
    src_e            mul_a;
    src_e            mul_b;
    post_e           post;
    dst_e            dst;
    logic            coef_ch;
    logic            dec_k;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
    logic            done;
  } ucode_t;

  // control word builder
  function automatic ucode_t uword(logic mul_en, src_e a, src_e b, post_e post, dst_e dst,
                                   logic ch, logic dec, jmp_e jmp, logic [PC_W-1:0] tgt,
                                   logic done);
    ucode_t w;
    w.mul_en  = mul_en;
    w.mul_a   = a;
    w.mul_b   = b;
    w.post    = post;
    w.dst     = dst;
    w.coef_ch = ch;
    w.dec_k   = dec;
    w.jmp     = jmp;
    w.target  = tgt;
    w.done    = done;
    return w;
  endfunction

  // program rom: interleaved horner for both channels, then kinematics
  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      PC_H0:    w = uword(1'b1, SRC_ACCL, SRC_XL, POST_NOP, DST_ACCL, 1'b0, 1'b0,
                          JMP_BYPASS, PC_BP, 1'b0);
      PC_H1:    w = uword(1'b1, SRC_ACCA, SRC_XA, POST_COEF, DST_ACCL, 1'b0, 1'b0,
                          JMP_KZERO, PC_HE, 1'b0);
      PC_H2:    w = uword(1'b1, SRC_ACCL, SRC_XL, POST_COEF, DST_ACCA, 1'b1, 1'b1,
                          JMP_ALWAYS, PC_H1, 1'b0);
      PC_HE:    w = uword(1'b1, SRC_INVR, SRC_ACCL, POST_COEF, DST_ACCA, 1'b1, 1'b0,
                          JMP_ALWAYS, PC_BASE, 1'b0);
      PC_BP:    w = uword(1'b1, SRC_INVR, SRC_ACCL, POST_NOP, DST_ACCL, 1'b0, 1'b0,
                          JMP_NONE, PC_H0, 1'b0);
      PC_BASE:  w = uword(1'b1, SRC_TERR, SRC_HTR, POST_MOV, DST_BASE, 1'b0, 1'b0,
                          JMP_NONE, PC_H0, 1'b0);
      PC_T1:    w = uword(1'b0, SRC_TERR, SRC_HTR, POST_MOV, DST_T1, 1'b0, 1'b0,
                          JMP_NONE, PC_H0, 1'b0);
      PC_TURN:  w = uword(1'b1, SRC_T1, SRC_ACCA, POST_NOP, DST_ACCL, 1'b0, 1'b0,
                          JMP_NONE, PC_H0, 1'b0);
      PC_DIF:   w = uword(1'b0, SRC_T1, SRC_ACCA, POST_BMINUS, DST_DIF, 1'b0, 1'b0,
                          JMP_NONE, PC_H0, 1'b0);
      PC_SUM:   w = uword(1'b1, SRC_LS, SRC_DIF, POST_BPLUS, DST_SUM, 1'b0, 1'b0,
                          JMP_NONE, PC_H0, 1'b0);
      PC_LEFT:  w = uword(1'b1, SRC_RS, SRC_SUM, POST_MOV, DST_LEFT, 1'b0, 1'b0,
                          JMP_NONE, PC_H0, 1'b0);
      PC_RIGHT: w = uword(1'b0, SRC_RS, SRC_SUM, POST_MOV, DST_RIGHT, 1'b0, 1'b0,
                          JMP_NONE, PC_H0, 1'b1);
      default:  w = uword(1'b0, SRC_ACCL, SRC_XL, POST_NOP, DST_ACCL, 1'b0, 1'b0,
                          JMP_NONE, PC_H0, 1'b1);
    endcase
    return w;
  endfunction

endpackage

@@ rtl/skid_steer_wheel_rate_mapper_unit.sv @@
`timescale 1ns / 1ps
// skid-steer wheel rate mapper: microcoded sequencer over one shared multiplier
//
//  channel | direction | handshake           | carries
//  --------+-----------+---------------------+-------------------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_item_t: coefficient load or command
//  out     | output    | out_valid_o/out_stall_i | out_item_t: wheel rates, saturated flag
//  cfg     | input     | cfg_valid_i/cfg_ready_o | register index and 32-bit write data
//
// a load yields no item
// a command runs 2*MAX_TERMS+6 program steps (22 at eight terms), 9 with sim_bypass,
// then frees the input to accept the next item; the single multiplier shared by both
// horner chains and the kinematics sets this figure, at most one product per step
// reset loads the register defaults and the identity polynomial in both tables
// a result waiting under out_stall_i holds the last program step; cfg_ready_o is always high
module skid_steer_wheel_rate_mapper_unit
  import sswrm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  localparam logic signed [31:0] ONE_FX    = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] RND_HALF  = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;
  localparam logic signed [33:0] S32_MAX_N = 34'sd2147483647;
  localparam logic signed [33:0] S32_MIN_N = -34'sd2147483648;
  localparam logic signed [31:0] S32_MAX   = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN   = 32'sh80000000;

  // configuration registers
  logic               sim_bypass_q;
  logic [30:0]        inv_radius_q;
  logic [30:0]        half_track_q;
  logic signed [31:0] min_lin_q, max_lin_q, min_ang_q, max_ang_q;

  // coefficient tables
  logic signed [31:0] coef_q [2][MAX_TERMS];

  // sequencer control
  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic [KW-1:0]   k_q, k_d;
  logic            sat_q, sat_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q;

  // datapath registers
  logic signed [31:0] acc_l_q, acc_a_q, x_l_q, x_a_q, terr_q, ls_q, rs_q;
  logic signed [31:0] base_q, t1_q, dif_q, sum_q, left_q;
  logic signed [63:0] prod_q;

  ucode_t             uw;
  logic               in_accept, cmd_accept, load_accept, step_en, jump;
  logic signed [31:0] lin_lo, lin_cl, ang_lo, ang_cl;
  logic signed [31:0] mul_a, mul_b, coef_rd, addend, r32, res;
  logic signed [63:0] r_wide;
  logic signed [33:0] s_wide;
  logic               r_sat, s_sat, step_sat;
  logic [KW-1:0]      load_idx;

  assign uw          = ucode_rom(pc_q);
  assign in_accept   = in_valid_i && !busy_q;
  assign cmd_accept  = in_accept && (in_data_i.op == OP_CMD);
  assign load_accept = in_accept && (in_data_i.op == OP_LOAD);
  assign step_en     = busy_q && !(uw.done && out_valid_q && out_stall_i);
  assign load_idx    = KW'(in_data_i.coef_index);

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // input clamps
  always_comb begin
    lin_lo = (in_data_i.linear_cmd < min_lin_q) ? min_lin_q : in_data_i.linear_cmd;
    lin_cl = (lin_lo > max_lin_q) ? max_lin_q : lin_lo;
    ang_lo = (in_data_i.angular_cmd < min_ang_q) ? min_ang_q : in_data_i.angular_cmd;
    ang_cl = (ang_lo > max_ang_q) ? max_ang_q : ang_lo;
  end

  // multiplier operand selects
  always_comb begin
    unique case (uw.mul_a)
      SRC_ACCL: mul_a = acc_l_q;
      SRC_ACCA: mul_a = acc_a_q;
      SRC_XL:   mul_a = x_l_q;
      SRC_XA:   mul_a = x_a_q;
      SRC_INVR: mul_a = $signed({1'b0, inv_radius_q});
      SRC_HTR:  mul_a = $signed({1'b0, half_track_q});
      SRC_TERR: mul_a = terr_q;
      SRC_T1:   mul_a = t1_q;
      SRC_LS:   mul_a = ls_q;
      SRC_RS:   mul_a = rs_q;
      SRC_DIF:  mul_a = dif_q;
      SRC_SUM:  mul_a = sum_q;
      default:  mul_a = '0;
    endcase
    unique case (uw.mul_b)
      SRC_ACCL: mul_b = acc_l_q;
      SRC_ACCA: mul_b = acc_a_q;
      SRC_XL:   mul_b = x_l_q;
      SRC_XA:   mul_b = x_a_q;
      SRC_INVR: mul_b = $signed({1'b0, inv_radius_q});
      SRC_HTR:  mul_b = $signed({1'b0, half_track_q});
      SRC_TERR: mul_b = terr_q;
      SRC_T1:   mul_b = t1_q;
      SRC_LS:   mul_b = ls_q;
      SRC_RS:   mul_b = rs_q;
      SRC_DIF:  mul_b = dif_q;
      SRC_SUM:  mul_b = sum_q;
      default:  mul_b = '0;
    endcase
  end

  // round-shift and saturate the held product, then optional saturating add or subtract
  always_comb begin
    coef_rd = coef_q[uw.coef_ch][k_q];
    r_wide  = prod_q >>> FRAC_BITS;
    r_sat   = (r_wide > S32_MAX_W) || (r_wide < S32_MIN_W);
    if (r_wide > S32_MAX_W) begin
      r32 = S32_MAX;
    end else if (r_wide < S32_MIN_W) begin
      r32 = S32_MIN;
    end else begin
      r32 = r_wide[31:0];
    end
    unique case (uw.post)
      POST_COEF:   addend = coef_rd;
      POST_BMINUS: addend = base_q;
      POST_BPLUS:  addend = base_q;
      default:     addend = '0;
    endcase
    if (uw.post == POST_BMINUS) begin
      s_wide = 34'(addend) - 34'(r32);
    end else begin
      s_wide = 34'(addend) + 34'(r32);
    end
    s_sat = (s_wide > S32_MAX_N) || (s_wide < S32_MIN_N);
    if (uw.post == POST_MOV || uw.post == POST_NOP) begin
      res      = r32;
      step_sat = r_sat && (uw.post == POST_MOV);
    end else begin
      if (s_wide > S32_MAX_N) begin
        res = S32_MAX;
      end else if (s_wide < S32_MIN_N) begin
        res = S32_MIN;
      end else begin
        res = s_wide[31:0];
      end
      step_sat = r_sat || s_sat;
    end
  end

  // sequencer next state
  always_comb begin
    busy_d      = busy_q;
    pc_d        = pc_q;
    k_d         = k_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (uw.jmp)
      JMP_ALWAYS: jump = 1'b1;
      JMP_BYPASS: jump = sim_bypass_q;
      JMP_KZERO:  jump = (k_q == '0);
      default:    jump = 1'b0;
    endcase
    if (cmd_accept) begin
      busy_d = 1'b1;
      pc_d   = PC_H0;
      k_d    = KW'(MAX_TERMS - 2);
      sat_d  = 1'b0;
    end else if (step_en) begin
      sat_d = sat_q || step_sat;
      if (uw.dec_k) begin
        k_d = k_q - KW'(1);
      end
      if (uw.done) begin
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
      end else if (jump) begin
        pc_d = uw.target;
      end else begin
        pc_d = pc_q + PC_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pc_q        <= PC_H0;
      k_q         <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      pc_q        <= pc_d;
      k_q         <= k_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sim_bypass_q <= 1'b0;
      inv_radius_q <= 31'(ONE_FX);
      half_track_q <= 31'(ONE_FX);
      min_lin_q    <= S32_MIN;
      max_lin_q    <= S32_MAX;
      min_ang_q    <= S32_MIN;
      max_ang_q    <= S32_MAX;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SIM_BYPASS:  sim_bypass_q <= cfg_data_i[0];
        CFG_INV_RADIUS:  inv_radius_q <= cfg_data_i[30:0];
        CFG_HALF_TRACK:  half_track_q <= cfg_data_i[30:0];
        CFG_MIN_LINEAR:  min_lin_q    <= $signed(cfg_data_i);
        CFG_MAX_LINEAR:  max_lin_q    <= $signed(cfg_data_i);
        CFG_MIN_ANGULAR: min_ang_q    <= $signed(cfg_data_i);
        CFG_MAX_ANGULAR: max_ang_q    <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // coefficient tables, identity polynomial after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < 2; t++) begin
        for (int k = 0; k < MAX_TERMS; k++) begin
          coef_q[t][k] <= (k == 1) ? ONE_FX : 32'sd0;
        end
      end
    end else if (load_accept && (32'(in_data_i.coef_index) < 32'(MAX_TERMS))) begin
      coef_q[in_data_i.channel][load_idx] <= in_data_i.coef_value;
    end
  end

  // datapath: operand capture, shared multiplier, post-op write back
  always_ff @(posedge clk_i) begin
    if (cmd_accept) begin
      x_l_q  <= lin_cl;
      x_a_q  <= ang_cl;
      acc_l_q <= sim_bypass_q ? in_data_i.linear_cmd : coef_q[0][MAX_TERMS-1];
      acc_a_q <= sim_bypass_q ? in_data_i.angular_cmd : coef_q[1][MAX_TERMS-1];
      terr_q <= in_data_i.terrain_factor;
      ls_q   <= in_data_i.left_scale;
      rs_q   <= in_data_i.right_scale;
    end else if (step_en) begin
      if (uw.mul_en) begin
        prod_q <= mul_a * mul_b + RND_HALF;
      end
      if (uw.post != POST_NOP) begin
        unique case (uw.dst)
          DST_ACCL:  acc_l_q <= res;
          DST_ACCA:  acc_a_q <= res;
          DST_BASE:  base_q  <= res;
          DST_T1:    t1_q    <= res;
          DST_DIF:   dif_q   <= res;
          DST_SUM:   sum_q   <= res;
          DST_LEFT:  left_q  <= res;
          DST_RIGHT: begin
            out_q.left_wheel_rate  <= left_q;
            out_q.right_wheel_rate <= res;
            out_q.saturated        <= sat_q || step_sat;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/sswrm_checker.sv @@
`timescale 1ns / 1ps
// port-level checker for the skid-steer wheel rate mapper, bound to the top level
module sswrm_checker
  import sswrm_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input in_item_t             in_data_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input out_item_t            out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // an accepted command occupies the sequencer
  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.op == OP_CMD) |=> in_stall_o)
    else $error("command accepted without going busy");

  // a coefficient load never produces an item
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.op == OP_LOAD && !out_valid_o) |=> !out_valid_o)
    else $error("coefficient load produced a result");

  // a new result only comes out of a running program
  a_out_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with the sequencer idle");

endmodule

bind skid_steer_wheel_rate_mapper_unit sswrm_checker u_checker (.*);
